FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/cfr_pkg.sv
package cfr_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 8'd1;

    localparam logic [7:0]  LOCAL_ADDRESS_RESET  = 8'd2;
    localparam logic [15:0] CRC_POLYNOMIAL_RESET = 16'h1021;

    typedef struct packed {
        logic [1:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] sender_address;
        logic [7:0] time_stamp;
        logic [7:0] command_code;
        logic [7:0] payload_length;
    } result_t;

    // MSB-first CRC16 update over one byte, no reflection.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/cfr_frame_fsm.sv
module cfr_frame_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       local_address,
    input  logic [15:0]      crc_polynomial,
    output cfr_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_DEST,
        PH_SENDER,
        PH_STAMP,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sender_reg, sender_next;
    logic [7:0]  stamp_reg, stamp_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [15:0] crc_fed;
    logic [7:0]  count_inc;

    assign crc_fed   = cfr_pkg::crc_feed(crc_reg, rx_byte, crc_polynomial);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        sender_next   = sender_reg;
        stamp_next    = stamp_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;

        result.status        = cfr_pkg::ST_BUSY;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;
        result.payload_index = 8'd0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfr_pkg::HEADER_BYTE)
                    phase_next = PH_DEST;
                else
                    result.status = cfr_pkg::ST_BAD_HDR;
            end
            PH_DEST:
            begin
                if (rx_byte == local_address)
                begin
                    crc_next   = cfr_pkg::crc_feed(16'd0, local_address, crc_polynomial);
                    phase_next = PH_SENDER;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SENDER:
            begin
                sender_next = rx_byte;
                crc_next    = crc_fed;
                phase_next  = PH_STAMP;
            end
            PH_STAMP:
            begin
                stamp_next = rx_byte;
                crc_next   = crc_fed;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                command_next = rx_byte;
                crc_next     = crc_fed;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                count_next  = 8'd0;
                crc_next    = crc_fed;
                phase_next  = (rx_byte != 8'd0) ? PH_DATA : PH_CRC_HI;
            end
            PH_DATA:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                crc_next             = crc_fed;
                count_next           = count_inc;
                if (count_inc == length_reg)
                    phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                crc_high_next = rx_byte;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                result.status = ({crc_high_reg, rx_byte} == crc_reg) ? cfr_pkg::ST_READY
                                                                     : cfr_pkg::ST_CRC_ERR;
                phase_next    = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        result.sender_address = sender_next;
        result.time_stamp     = stamp_next;
        result.command_code   = command_next;
        result.payload_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            sender_reg   <= 8'd0;
            stamp_reg    <= 8'd0;
            command_reg  <= 8'd0;
            length_reg   <= 8'd0;
            count_reg    <= 8'd0;
            crc_reg      <= 16'd0;
            crc_high_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            sender_reg   <= sender_next;
            stamp_reg    <= stamp_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

FILE: rtl/cfr_config_regs.sv
module cfr_config_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]                      local_address,
    output logic [15:0]                     crc_polynomial
);

    logic [7:0]  local_address_reg;
    logic [15:0] crc_polynomial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg  <= cfr_pkg::LOCAL_ADDRESS_RESET;
            crc_polynomial_reg <= cfr_pkg::CRC_POLYNOMIAL_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                cfr_pkg::REG_LOCAL_ADDRESS:  local_address_reg  <= cfg_data[7:0];
                cfr_pkg::REG_CRC_POLYNOMIAL: crc_polynomial_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign local_address  = local_address_reg;
    assign crc_polynomial = crc_polynomial_reg;

endmodule

FILE: rtl/crc16_frame_receiver.sv
// Byte-serial frame receiver: each input item is one received byte and yields exactly one
// result item carrying the frame status, the payload byte with its index when the byte was
// payload, and the latched sender, timestamp, command and length fields. The block accepts
// one item per cycle while the output is not stalled. Each accepted item waits in the input
// register; its result is loaded into the result register once the output is free and is
// taken at an edge where out_stall is low. While the output is stalled the result register
// and the input register each hold one item, and the input stalls once both are full. The
// per-item path is the frame state machine plus unrolled eight-bit CRC16 updates between
// the input and result registers. Configuration writes are expected only while idle.
`include "assert_macros.svh"

module crc16_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write_enable,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic                            payload_valid,
    output logic [7:0]                      payload_byte,
    output logic [7:0]                      payload_index,
    output logic [7:0]                      sender_address,
    output logic [7:0]                      time_stamp,
    output logic [7:0]                      command_code,
    output logic [7:0]                      payload_length
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    cfr_pkg::result_t  result_reg;
    cfr_pkg::result_t  step_result;
    logic              out_free;
    logic              step_en;
    logic              in_take;
    logic [7:0]        local_address;
    logic [15:0]       crc_polynomial;

    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    cfr_config_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .local_address    (local_address),
        .crc_polynomial   (crc_polynomial)
    );

    cfr_frame_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .rx_byte        (in_byte_reg),
        .local_address  (local_address),
        .crc_polynomial (crc_polynomial),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign payload_valid  = result_reg.payload_valid;
    assign payload_byte   = result_reg.payload_byte;
    assign payload_index  = result_reg.payload_index;
    assign sender_address = result_reg.sender_address;
    assign time_stamp     = result_reg.time_stamp;
    assign command_code   = result_reg.command_code;
    assign payload_length = result_reg.payload_length;

    `ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)
    `ASSERT_IMPLY(a_payload_in_progress, clk, rst_n, out_valid && payload_valid, status == cfr_pkg::ST_BUSY)
    `ASSERT_NEXT(a_out_drains_empty, clk, rst_n, out_valid_reg && !out_stall && !in_valid_reg, !out_valid_reg)

endmodule
